>>> sv/srsf_pkg.sv
// ============================================================================
// srsf_pkg : shared types and constants of the register sample FIFO
// Opcodes, register addresses and fixed identification words.
// ============================================================================
package srsf_pkg;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_FRAME = 2'd0;
  localparam opcode_t OP_TICK  = 2'd1;
  localparam opcode_t OP_LINK  = 2'd2;
  localparam opcode_t OP_NONE  = 2'd3;

  localparam logic [6:0] A_ID      = 7'h00;
  localparam logic [6:0] A_VERSION = 7'h01;
  localparam logic [6:0] A_STATUS  = 7'h02;
  localparam logic [6:0] A_CONTROL = 7'h03;
  localparam logic [6:0] A_RATE    = 7'h04;
  localparam logic [6:0] A_LEVEL   = 7'h05;
  localparam logic [6:0] A_SEQ     = 7'h06;
  localparam logic [6:0] A_VALUE   = 7'h07;
  localparam logic [6:0] A_DROPS   = 7'h08;
  localparam logic [6:0] A_REARM   = 7'h09;
  localparam logic [6:0] A_LINKERR = 7'h0A;
  localparam logic [6:0] A_NULL    = 7'h7F;

  localparam logic [31:0] ID_WORD      = 32'hAC00ACC0;
  localparam logic [31:0] VERSION_WORD = 32'h00010300;
  localparam logic [13:0] RATE_MAX     = 14'd10000;
  localparam logic [13:0] RATE_RESET   = 14'd1000;

endpackage

>>> sv/spi_register_sample_fifo.sv
// ============================================================================
// spi_register_sample_fifo : slave register device with a sample FIFO
// Decodes link frames, counts base ticks into samples, buffers them, counts link errors.
// ============================================================================
// Usage
//   Input channel (in_valid / in_stall): one request per item, carrying
//   opcode, command_byte and write_data. Opcode 0 is a link frame, 1 a base
//   tick, 2 a link error event, 3 does nothing.
//   Output channel (out_valid / out_stall): exactly one result request per
//   input request: echo_byte, response_word, fifo_nonempty, sample_toggle.
//   Timing: a request is accepted only while no earlier one is in work or
//   waiting at the output. The head entry is read in the cycle after
//   acceptance and the result shows in the cycle after that, unless a
//   start or an in-range rate write while running first runs the 14-step
//   period divider.
//   Sample memory: two synchronous RAMs of SLOT_COUNT entries hold sequence
//   and value; the head entry is read on every request and the FIFO keeps at
//   most SLOT_COUNT-1 items.
//   Reset: synchronous, clears all control state; rate returns to 1000.
//   Stall: the result holds in the output register until taken; no new
//   request is accepted meanwhile.
// ============================================================================
module spi_register_sample_fifo #(
  parameter int SLOT_COUNT   = 32,
  parameter int BASE_TICK_HZ = 10000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  srsf_pkg::opcode_t     opcode,
  input  logic [7:0]            command_byte,
  input  logic [31:0]           write_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            echo_byte,
  output logic [31:0]           response_word,
  output logic                  fifo_nonempty,
  output logic                  sample_toggle
);
  import srsf_pkg::*;

  localparam int AW = $clog2(SLOT_COUNT);
  localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]    state;
  opcode_t       op_q;
  logic [7:0]    cmd_q;
  logic [31:0]   data_q;

  logic [AW-1:0] write_slot, read_slot;
  logic [31:0]   drop_count, next_sequence, link_error_count;
  logic [3:0]    status_flags;
  logic          running;
  logic [13:0]   rate_setting, period_reload, period_count;
  logic [15:0]   held_value;
  logic          held_flag, marker_level;

  logic [31:0]   seq_rd;
  logic [15:0]   val_rd;
  logic          mem_we;

  logic          div_start, div_busy;
  logic [13:0]   div_q;

  logic          accept;
  logic          empty;
  logic [AW-1:0] wr_inc, rd_inc, fill;
  logic [6:0]    addr;
  logic          is_write;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);
  assign empty    = (write_slot == read_slot);
  assign wr_inc   = (write_slot == LAST) ? '0 : write_slot + 1'b1;
  assign rd_inc   = (read_slot == LAST) ? '0 : read_slot + 1'b1;
  // wrap the distance by the slot count, which need not be a power of two
  assign fill     = (write_slot >= read_slot) ? write_slot - read_slot
                                              : write_slot - read_slot + AW'(SLOT_COUNT);
  assign addr     = cmd_q[6:0];
  assign is_write = cmd_q[7];
  assign fifo_nonempty = !empty;
  assign sample_toggle = marker_level;

  // a sample write happens on a tick that fires with room in the FIFO
  assign mem_we = (state == S_READ) && (op_q == OP_TICK) && running &&
                  (period_count >= period_reload) && (wr_inc != read_slot);

  srsf_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_seq (
    .clk(clk), .we(mem_we), .waddr(write_slot), .wdata(next_sequence),
    .raddr(read_slot), .rdata(seq_rd));

  srsf_ram #(.WIDTH(16), .DEPTH(SLOT_COUNT)) u_val (
    .clk(clk), .we(mem_we), .waddr(write_slot), .wdata(next_sequence[15:0]),
    .raddr(read_slot), .rdata(val_rd));

  // rate write while running needs a fresh reload; control start too
  assign div_start = (state == S_READ) && (op_q == OP_FRAME) && is_write &&
                     (((addr == A_RATE) && running && (data_q >= 32'd1) &&
                       (data_q <= 32'(RATE_MAX))) ||
                      ((addr == A_CONTROL) && data_q[0]));

  srsf_div #(.BASE_TICK_HZ(BASE_TICK_HZ)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .divisor((addr == A_RATE) ? data_q[13:0] : rate_setting),
    .busy(div_busy), .quotient(div_q));

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= opcode;
      cmd_q  <= command_byte;
      data_q <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      write_slot <= '0; read_slot <= '0;
      drop_count <= '0; next_sequence <= '0; link_error_count <= '0;
      status_flags <= '0; running <= 1'b0;
      rate_setting <= RATE_RESET; period_reload <= 14'd9; period_count <= '0;
      held_value <= '0; held_flag <= 1'b0;
      marker_level <= 1'b0;
      echo_byte <= '0; response_word <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_READ;
        end
        S_READ: begin
          // head entry data is valid now
          echo_byte <= '0;
          response_word <= '0;
          state <= div_start ? S_DIV : S_OUT;
          unique case (op_q)
            OP_FRAME: begin
              echo_byte <= cmd_q;
              if (is_write) begin
                if (addr == A_CONTROL) begin
                  if (data_q[1]) status_flags[3:1] <= '0;
                  running <= data_q[0];
                  status_flags[0] <= data_q[0];
                  if (data_q[0]) begin
                    next_sequence <= '0; write_slot <= '0; read_slot <= '0;
                    drop_count <= '0; held_flag <= 1'b0; period_count <= '0;
                  end
                end else if (addr == A_RATE) begin
                  if (data_q >= 32'd1 && data_q <= 32'(RATE_MAX)) begin
                    rate_setting <= data_q[13:0];
                    if (running) period_count <= '0;
                  end else begin
                    status_flags[2] <= 1'b1;
                  end
                end else begin
                  status_flags[1] <= 1'b1;
                end
              end else begin
                unique case (addr)
                  A_ID:      response_word <= ID_WORD;
                  A_VERSION: response_word <= VERSION_WORD;
                  A_STATUS:  response_word <= 32'(status_flags);
                  A_CONTROL: response_word <= 32'(running);
                  A_RATE:    response_word <= 32'(rate_setting);
                  A_LEVEL:   response_word <= 32'(fill);
                  A_SEQ: begin
                    if (!empty) begin
                      held_value <= val_rd;
                      held_flag <= 1'b1;
                      response_word <= seq_rd;
                    end
                  end
                  A_VALUE: begin
                    if (held_flag) begin
                      held_flag <= 1'b0;
                      response_word <= 32'(held_value);
                      if (!empty) read_slot <= rd_inc;
                    end else if (!empty) begin
                      held_value <= val_rd;
                      response_word <= 32'(val_rd);
                      read_slot <= rd_inc;
                    end
                  end
                  A_DROPS:   response_word <= drop_count;
                  A_REARM:   response_word <= '0;
                  A_LINKERR: response_word <= link_error_count;
                  A_NULL:    response_word <= '0;
                  default:   status_flags[1] <= 1'b1;
                endcase
              end
            end
            OP_TICK: begin
              if (running) begin
                if (period_count >= period_reload) begin
                  period_count <= '0;
                  marker_level <= ~marker_level;
                  if (wr_inc == read_slot) begin
                    drop_count <= drop_count + 32'd1;
                  end else begin
                    next_sequence <= next_sequence + 32'd1;
                    write_slot <= wr_inc;
                  end
                end else begin
                  period_count <= period_count + 14'd1;
                end
              end
            end
            OP_LINK: begin
              link_error_count <= link_error_count + 32'd1;
              status_flags[3] <= 1'b1;
            end
            OP_NONE: ;
            default: ;
          endcase
        end
        S_DIV: begin
          // hold until the quotient is in, then load the reload
          if (!div_busy) begin
            period_reload <= (div_q == '0) ? '0 : div_q - 14'd1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/srsf_ram.sv
// ============================================================================
// srsf_ram : generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ============================================================================
module srsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> sv/srsf_div.sv
// ============================================================================
// srsf_div : sequential restoring divider for the period reload
// Computes BASE / rate, one quotient bit per cycle.
// ============================================================================
module srsf_div #(
  parameter int BASE_TICK_HZ = 10000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [13:0] divisor,
  output logic        busy,
  output logic [13:0] quotient
);
  logic [13:0] rem;
  logic [13:0] quo;
  logic [13:0] dvs;
  logic [3:0]  count;
  logic [14:0] trial;

  assign trial = {rem, quo[13]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 4'd13;
    end else if (busy) begin
      if (count == 4'd0) busy <= 1'b0;
      count <= count - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= 14'(BASE_TICK_HZ);
      dvs <= divisor;
    end else if (busy) begin
      // shift in the next dividend bit, subtract where it fits
      if (trial >= {1'b0, dvs}) begin
        rem <= 14'(trial - {1'b0, dvs});
        quo <= {quo[12:0], 1'b1};
      end else begin
        rem <= trial[13:0];
        quo <= {quo[12:0], 1'b0};
      end
    end
  end
endmodule

>>> sv/srsf_checker.sv
// ============================================================================
// srsf_checker : port-level checks of the register sample FIFO
// Request ordering and result framing seen at the top-level ports.
// ============================================================================
module srsf_port_props (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  echo_byte,
  input logic [31:0] response_word
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(response_word) && $stable(echo_byte))
    else $error("stalled result changed");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken while a result waits");

  a_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result shown in the cycle after acceptance");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind spi_register_sample_fifo srsf_port_props u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .echo_byte(echo_byte), .response_word(response_word));
